### design/sfr_pkg.sv
// shared types, constants and byte functions of the serial link packet framer
`timescale 1ns / 1ps

package sfr_pkg;

    // frame layout
    localparam int          HDR_BYTES      = 10;
    localparam int          HDR_IDX_W      = 4;
    localparam logic [HDR_IDX_W-1:0] HDR_LAST_IDX = HDR_IDX_W'(HDR_BYTES - 1);
    localparam logic [7:0]  SIG_BYTE0      = 8'hBE;
    localparam logic [7:0]  SIG_BYTE1      = 8'hEF;
    localparam logic [7:0]  SIG_BYTE2      = 8'hED;
    localparam logic [15:0] CRC_POLY       = 16'h1021;

    // body length bound
    localparam int          MAX_BODY_BYTES = 255;
    localparam logic [7:0]  LEN_MAX        = 8'(MAX_BODY_BYTES);

    // depth of the queue between front and back
    localparam int          QUEUE_DEPTH_DEF = 4;

    // configuration register indexes
    localparam int          CFG_IDX_W          = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_SOCKET    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_SOCKET     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PACKET_TYPE    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TRANSACTION_ID = 2'd3;

    // header byte positions
    localparam logic [HDR_IDX_W-1:0] HDR_SIG0  = 4'd0;
    localparam logic [HDR_IDX_W-1:0] HDR_SIG1  = 4'd1;
    localparam logic [HDR_IDX_W-1:0] HDR_SIG2  = 4'd2;
    localparam logic [HDR_IDX_W-1:0] HDR_DEST  = 4'd3;
    localparam logic [HDR_IDX_W-1:0] HDR_SRC   = 4'd4;
    localparam logic [HDR_IDX_W-1:0] HDR_TYPE  = 4'd5;
    localparam logic [HDR_IDX_W-1:0] HDR_SIZEH = 4'd6;
    localparam logic [HDR_IDX_W-1:0] HDR_SIZEL = 4'd7;
    localparam logic [HDR_IDX_W-1:0] HDR_TID   = 4'd8;
    localparam logic [HDR_IDX_W-1:0] HDR_SUM   = 4'd9;

    typedef struct packed {
        logic [7:0] body_byte;
        logic [7:0] body_len;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       frame_end;
    } out_item_t;

    typedef struct packed {
        logic [7:0] dest_socket;
        logic [7:0] src_socket;
        logic [7:0] packet_type;
        logic [7:0] transaction_id;
    } cfg_t;

    // classified body byte handed from front to back
    typedef struct packed {
        logic [7:0] body_byte;
        logic [7:0] len;
        logic       first;
        logic       last;
    } cmd_t;

    typedef enum logic [1:0] {
        PH_HDR,
        PH_BODY,
        PH_CRC_HI,
        PH_CRC_LO
    } phase_t;

    // crc-16 over one byte, msb first
    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

    // header byte at a position
    function automatic logic [7:0] hdr_byte(input logic [HDR_IDX_W-1:0] idx,
                                            input cfg_t cfg, input logic [7:0] len);
        logic [7:0] sum;
        logic [7:0] b;
        sum = SIG_BYTE0 + SIG_BYTE1 + SIG_BYTE2 + cfg.dest_socket + cfg.src_socket
            + cfg.packet_type + len + cfg.transaction_id;
        case (idx)
            HDR_SIG0:  b = SIG_BYTE0;
            HDR_SIG1:  b = SIG_BYTE1;
            HDR_SIG2:  b = SIG_BYTE2;
            HDR_DEST:  b = cfg.dest_socket;
            HDR_SRC:   b = cfg.src_socket;
            HDR_TYPE:  b = cfg.packet_type;
            HDR_SIZEH: b = 8'h00;
            HDR_SIZEL: b = len;
            HDR_TID:   b = cfg.transaction_id;
            HDR_SUM:   b = sum;
            default:   b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

### design/sfr_front.sv
// front end: accepts body bytes and marks first and last byte of each packet
`timescale 1ns / 1ps

module sfr_front
    import sfr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  in_item_t item,
    output logic     full,
    input  logic     q_full,
    output logic     q_push,
    output cmd_t     q_cmd
);

    logic       in_frame_reg, in_frame_next;
    logic [7:0] bytes_left_reg, bytes_left_next;
    logic [7:0] len_sat;
    logic [7:0] left;
    logic       accept;

    assign full   = q_full;
    assign accept = push && !q_full;
    assign q_push = accept;

    // clamp the sampled length into 1..max
    always_comb
    begin
        if (item.body_len == 8'd0)
            len_sat = 8'd1;
        else if (item.body_len > LEN_MAX)
            len_sat = LEN_MAX;
        else
            len_sat = item.body_len;
    end

    // classify the beat
    always_comb
    begin
        left            = in_frame_reg ? bytes_left_reg : len_sat;
        q_cmd.body_byte = item.body_byte;
        q_cmd.len       = len_sat;
        q_cmd.first     = !in_frame_reg;
        q_cmd.last      = (left == 8'd1);
        in_frame_next   = in_frame_reg;
        bytes_left_next = bytes_left_reg;
        if (accept)
        begin
            in_frame_next   = (left != 8'd1);
            bytes_left_next = left - 8'd1;
        end
    end

    // packet tracking state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg   <= 1'b0;
            bytes_left_reg <= 8'd0;
        end
        else
        begin
            in_frame_reg   <= in_frame_next;
            bytes_left_reg <= bytes_left_next;
        end
    end

endmodule

### design/sfr_queue.sv
// short command queue between front and back
`timescale 1ns / 1ps

module sfr_queue
    import sfr_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  cmd_t wr_data,
    output logic q_full,
    input  logic rd_en,
    output cmd_t rd_data,
    output logic q_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    cmd_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign q_full  = (count_reg == CNT_FULL);
    assign q_empty = (count_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_data = entry_reg[rd_ptr_reg];

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
            entry_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

### design/sfr_back.sv
// back end: sequences header, body and crc beats into the output register
`timescale 1ns / 1ps

module sfr_back
    import sfr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  cmd_t      q_cmd,
    input  logic      q_empty,
    output logic      q_pop,
    output out_item_t result,
    output logic      empty,
    input  logic      pop
);

    logic                 busy_reg, busy_next;
    cmd_t                 cmd_reg;
    phase_t               phase_reg, phase_next;
    logic [HDR_IDX_W-1:0] idx_reg, idx_next;
    logic [15:0]          crc_reg, crc_next;
    logic                 out_valid_reg, out_valid_next;
    out_item_t            out_reg;
    out_item_t            beat;
    logic [15:0]          crc_base;
    logic                 crc_upd;
    logic                 cmd_done;
    logic                 advance;
    logic                 load;

    assign result  = out_reg;
    assign empty   = !out_valid_reg;
    assign advance = busy_reg && (!out_valid_reg || pop);
    assign load    = (!busy_reg || (advance && cmd_done)) && !q_empty;
    assign q_pop   = load;

    // next phase of the sequencer
    always_comb
    begin
        phase_next = phase_reg;
        idx_next   = idx_reg;
        cmd_done   = 1'b0;
        unique case (phase_reg)
            PH_HDR:
            begin
                if (idx_reg == HDR_LAST_IDX)
                    phase_next = PH_BODY;
                idx_next = idx_reg + 1'b1;
            end
            PH_BODY:
            begin
                if (cmd_reg.last)
                    phase_next = PH_CRC_HI;
                else
                    cmd_done = 1'b1;
            end
            PH_CRC_HI:
                phase_next = PH_CRC_LO;
            PH_CRC_LO:
                cmd_done = 1'b1;
        endcase
    end

    // beat produced in the current phase
    always_comb
    begin
        beat.run_last  = 1'b0;
        beat.frame_end = 1'b0;
        crc_upd        = 1'b0;
        crc_base       = crc_reg;
        unique case (phase_reg)
            PH_HDR:
            begin
                beat.out_byte = hdr_byte(idx_reg, cfg, cmd_reg.len);
                crc_upd       = 1'b1;
                if (idx_reg == '0)
                    crc_base = 16'h0000;
            end
            PH_BODY:
            begin
                beat.out_byte = cmd_reg.body_byte;
                beat.run_last = !cmd_reg.last;
                crc_upd       = 1'b1;
            end
            PH_CRC_HI:
                beat.out_byte = crc_reg[15:8];
            PH_CRC_LO:
            begin
                beat.out_byte  = crc_reg[7:0];
                beat.run_last  = 1'b1;
                beat.frame_end = 1'b1;
            end
        endcase
        crc_next = crc_upd ? crc_update(crc_base, beat.out_byte) : crc_reg;
    end

    // busy and output valid
    always_comb
    begin
        busy_next = busy_reg;
        if (load)
            busy_next = 1'b1;
        else if (!busy_reg || (advance && cmd_done))
            busy_next = 1'b0;
        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (pop)
            out_valid_next = 1'b0;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            phase_reg     <= PH_HDR;
            idx_reg       <= '0;
            crc_reg       <= 16'h0000;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
            if (advance)
                crc_reg <= crc_next;
            if (load)
            begin
                phase_reg <= q_cmd.first ? PH_HDR : PH_BODY;
                idx_reg   <= '0;
            end
            else if (advance)
            begin
                phase_reg <= phase_next;
                idx_reg   <= idx_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (load)
            cmd_reg <= q_cmd;
        if (advance)
            out_reg <= beat;
    end

endmodule

### design/serial_link_packet_framer_core.sv
// top level of the serial link packet framer
//
// Input channel: one body byte per beat with the packet length; a beat is
// taken when push is high and full is low. The length is sampled on the
// first byte of each packet (0 is taken as 1).
// Result channel: the framed byte stream; the oldest beat is shown while
// empty is low and is taken when pop is high. run_last marks the final beat
// caused by an input beat, frame_end the second crc byte of a packet.
// Configuration: cfg_wr_en writes cfg_data into the register cfg_index
// (dest, src, type, transaction id) at once; write only while idle.
// When the block is idle, an input beat passes the command queue, the
// command register and the output register before its first result shows.
// Throughput: results leave at one beat per cycle while the receiver pops and
// the queue holds commands; a packet of N body bytes gives N + 12 beats.
// Input beats are taken one per cycle until the command queue (QUEUE_DEPTH
// entries) fills behind the back-end sequencer. A stalled receiver holds the
// output register, the sequencer then stops and the queue fills, after which full rises.
// Reset clears the queue, the packet state and the output valid flag, and
// sets the header registers to their defaults.
`timescale 1ns / 1ps

module serial_link_packet_framer_core
    import sfr_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  in_item_t             item,
    output logic                 full,
    output out_item_t            result,
    output logic                 empty,
    input  logic                 pop,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data
);

    cfg_t cfg_reg;
    cmd_t f_cmd;
    cmd_t q_cmd;
    logic f_push;
    logic q_full;
    logic q_empty;
    logic q_pop;

    // header configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dest_socket    <= 8'd1;
            cfg_reg.src_socket     <= 8'd1;
            cfg_reg.packet_type    <= 8'd0;
            cfg_reg.transaction_id <= 8'd1;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_DEST_SOCKET:    cfg_reg.dest_socket    <= cfg_data;
                CFG_SRC_SOCKET:     cfg_reg.src_socket     <= cfg_data;
                CFG_PACKET_TYPE:    cfg_reg.packet_type    <= cfg_data;
                CFG_TRANSACTION_ID: cfg_reg.transaction_id <= cfg_data;
            endcase
        end
    end

    // front end
    sfr_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .item   (item),
        .full   (full),
        .q_full (q_full),
        .q_push (f_push),
        .q_cmd  (f_cmd)
    );

    // command queue
    sfr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (f_push),
        .wr_data (f_cmd),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .rd_data (q_cmd),
        .q_empty (q_empty)
    );

    // back end
    sfr_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_cmd   (q_cmd),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .result  (result),
        .empty   (empty),
        .pop     (pop)
    );

endmodule

### bench/testbench.sv
// self-checking bench for the serial link packet framer: header, body pass-through and crc
`timescale 1ns / 1ps

module testbench
    import sfr_pkg::*;
;

    localparam int DRAIN_CYCLES  = 16;
    localparam int END_WAIT_MAX  = 200000;
    localparam int PHASE_BEATS   = 45;

    // expected line bytes of the framer, built from accepted body beats
    class frame_model;
        logic [7:0]  dest_id;
        logic [7:0]  src_id;
        logic [7:0]  pkt_type;
        logic [7:0]  trans_id;
        bit          in_packet;
        logic [7:0]  left_in_body;
        logic [15:0] running_crc;
        out_item_t   line_bytes[$];
        int unsigned mismatches;
        int unsigned checked;
        int unsigned beats;
        int unsigned packets;

        function new();
            dest_id      = 8'd1;
            src_id       = 8'd1;
            pkt_type     = 8'd0;
            trans_id     = 8'd1;
            in_packet    = 1'b0;
            left_in_body = 8'd0;
            running_crc  = 16'h0000;
            mismatches   = 0;
            checked      = 0;
            beats        = 0;
            packets      = 0;
        endfunction

        function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] v);
            case (idx)
                CFG_DEST_SOCKET:    dest_id  = v;
                CFG_SRC_SOCKET:     src_id   = v;
                CFG_PACKET_TYPE:    pkt_type = v;
                CFG_TRANSACTION_ID: trans_id = v;
                default: ;
            endcase
        endfunction

        // crc-16 step, feeding the byte in one bit at a time, msb first
        function logic [15:0] crc_shift(input logic [15:0] crc, input logic [7:0] b);
            logic [15:0] c;
            logic        fb;
            c = crc;
            for (int i = 7; i >= 0; i--) begin
                fb = c[15] ^ b[i];
                c  = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
            end
            return c;
        endfunction

        function void emit(input logic [7:0] b, input bit last_of_beat, input bit end_of_frame);
            out_item_t r;
            r.out_byte  = b;
            r.run_last  = last_of_beat;
            r.frame_end = end_of_frame;
            line_bytes.push_back(r);
            running_crc = crc_shift(running_crc, b);
        endfunction

        // note an accepted body beat and queue the line bytes it causes
        function void take_beat(input in_item_t it);
            logic [7:0]  len;
            logic [7:0]  hdr[HDR_BYTES];
            logic [7:0]  sum;
            logic [15:0] crc_out;
            beats++;
            if (!in_packet) begin
                // zero length counts as one byte; the 8-bit field cannot exceed the bound
                len = (it.body_len == 8'd0) ? 8'd1 : it.body_len;
                hdr[0] = SIG_BYTE0;
                hdr[1] = SIG_BYTE1;
                hdr[2] = SIG_BYTE2;
                hdr[3] = dest_id;
                hdr[4] = src_id;
                hdr[5] = pkt_type;
                hdr[6] = 8'h00;
                hdr[7] = len;
                hdr[8] = trans_id;
                sum = 8'h00;
                for (int i = 0; i < HDR_BYTES - 1; i++)
                    sum = sum + hdr[i];
                hdr[9] = sum;
                running_crc = 16'h0000;
                for (int i = 0; i < HDR_BYTES; i++)
                    emit(hdr[i], 1'b0, 1'b0);
                left_in_body = len;
                in_packet    = 1'b1;
                packets++;
            end
            left_in_body = left_in_body - 8'd1;
            emit(it.body_byte, left_in_body != 8'd0, 1'b0);
            // packet done: crc over header and body, high byte first
            if (left_in_body == 8'd0) begin
                crc_out = running_crc;
                emit(crc_out[15:8], 1'b0, 1'b0);
                emit(crc_out[7:0], 1'b1, 1'b1);
                in_packet   = 1'b0;
                running_crc = 16'h0000;
            end
        endfunction

        function void note_fail(input string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("%s", msg);
        endfunction

        // compare one popped line byte with the oldest expected one
        function void check_line_byte(input out_item_t got);
            out_item_t want;
            bit        bad;
            checked++;
            if (line_bytes.size() == 0) begin
                note_fail($sformatf("unexpected line byte %02h run_last %0b frame_end %0b",
                                    got.out_byte, got.run_last, got.frame_end));
                return;
            end
            want = line_bytes.pop_front();
            bad  = 1'b0;
            if (got.out_byte !== want.out_byte)
                bad = 1'b1;
            if (got.run_last !== want.run_last)
                bad = 1'b1;
            if (got.frame_end !== want.frame_end)
                bad = 1'b1;
            if (bad)
                note_fail($sformatf({"mismatch at line byte %0d: expected %02h/%0b/%0b,",
                                     " got %02h/%0b/%0b (byte/run_last/frame_end)"},
                                    checked, want.out_byte, want.run_last, want.frame_end,
                                    got.out_byte, got.run_last, got.frame_end));
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 push;
    in_item_t             item;
    logic                 full;
    out_item_t            result;
    logic                 empty;
    logic                 pop;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [7:0]           cfg_data;

    frame_model model = new();
    bit         tx_idle_on;
    bit         rx_idle_on;
    int         stall_left;
    int         settings_used;

    serial_link_packet_framer_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item      (item),
        .full      (full),
        .result    (result),
        .empty     (empty),
        .pop       (pop),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    // run limit
    initial
    begin
        #2000000;
        $display("testbench: FAIL");
        $finish;
    end

    // receiver: pop with random stall bursts
    always @(negedge clk)
    begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            pop        <= 1'b0;
        end
        else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 14);
            pop        <= 1'b0;
        end
        else begin
            pop <= 1'b1;
        end
    end

    // monitor: accepted beats on both sides
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (push && !full)
                model.take_beat(item);
            if (pop && !empty)
                model.check_line_byte(result);
        end
    end

    // one body beat, with an optional idle burst ahead of it
    task automatic send_beat(input in_item_t b);
        if (tx_idle_on && $urandom_range(0, 5) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        push <= 1'b1;
        item <= b;
        forever begin
            @(posedge clk);
            if (!full)
                break;
        end
        @(negedge clk);
    endtask

    // one packet with random body; length field on later beats is noise
    task automatic send_random_packet(input logic [7:0] len_field);
        int       n;
        in_item_t b;
        n = (len_field == 8'd0) ? 1 : int'(len_field);
        for (int i = 0; i < n; i++) begin
            b.body_byte = 8'($urandom);
            b.body_len  = (i == 0) ? len_field : 8'($urandom);
            send_beat(b);
        end
    endtask

    function automatic logic [7:0] pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return 8'd0;
        else if (r < 12)
            return 8'd1;
        else if (r < 20)
            return 8'($urandom_range(9, 40));
        else
            return 8'($urandom_range(2, 8));
    endfunction

    // stop sending and wait until all line bytes are out
    task automatic wait_drained();
        push <= 1'b0;
        while (model.line_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    // write all four header registers, one per cycle
    task automatic write_header_regs(input logic [7:0] d, input logic [7:0] s,
                                     input logic [7:0] t, input logic [7:0] x);
        logic [CFG_IDX_W-1:0] idx[4];
        logic [7:0]           val[4];
        idx = '{CFG_DEST_SOCKET, CFG_SRC_SOCKET, CFG_PACKET_TYPE, CFG_TRANSACTION_ID};
        val = '{d, s, t, x};
        for (int i = 0; i < 4; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            model.set_reg(idx[i], val[i]);
            @(negedge clk);
        end
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    task automatic random_phase(input bit with_long);
        int start;
        start = model.beats;
        if (with_long)
            send_random_packet(LEN_MAX);
        while (model.beats - start < PHASE_BEATS)
            send_random_packet(pick_len());
    endtask

    // main sequence
    initial
    begin
        int spins;
        rst_n         = 1'b0;
        push          = 1'b0;
        item          = '0;
        pop           = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = CFG_DEST_SOCKET;
        cfg_data      = 8'h00;
        tx_idle_on    = 1'b0;
        rx_idle_on    = 1'b0;
        stall_left    = 0;
        settings_used = 1;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed beats under the reset header values
        // one-byte packet, then a zero length taken as one
        send_beat({8'h00, 8'd1});
        send_beat({8'hFF, 8'd0});
        // three bytes; length on later beats is ignored
        send_beat({8'h00, 8'd3});
        send_beat({8'hFF, 8'd0});
        send_beat({8'h5A, 8'hFF});
        send_beat({8'hFF, 8'd2});
        send_beat({8'h00, 8'd1});
        send_beat({8'h80, 8'd4});
        send_beat({8'h01, 8'hAA});
        send_beat({8'h7F, 8'h55});
        send_beat({8'hFE, 8'd9});
        for (int i = 0; i < 8; i++)
            send_beat({8'(8'h11 * i), (i == 0) ? 8'd8 : 8'(i)});

        // random packets over several header settings
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        random_phase(1'b0);
        wait_drained();
        write_header_regs(8'h00, 8'h00, 8'h00, 8'h00);
        random_phase(1'b0);
        wait_drained();
        write_header_regs(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        random_phase(1'b1);
        for (int p = 0; p < 3; p++) begin
            wait_drained();
            write_header_regs(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
            if (p == 2) begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end
            random_phase(1'b0);
        end
        push <= 1'b0;

        // let everything drain, then look for strays
        spins = 0;
        while (model.line_bytes.size() != 0 && spins < END_WAIT_MAX) begin
            @(posedge clk);
            spins++;
        end
        if (model.line_bytes.size() != 0)
            model.note_fail($sformatf("%0d expected line bytes never arrived",
                                      model.line_bytes.size()));
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("summary: %0d body beats in %0d packets, %0d line bytes checked",
                 model.beats, model.packets, model.checked);
        $display("summary: %0d header settings, %0d failures", settings_used, model.mismatches);
        if (model.mismatches == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
